// File: rtl/crg_pkg.sv
package crg_pkg;

   // device time at or below this value means the clock is not synced yet
   localparam logic [31:0] SYNC_THRESHOLD = 32'd1000000000;
   localparam logic [31:0] WINDOW_RESET   = 32'd300;

   localparam logic [2:0] REASON_NONE      = 3'd0;
   localparam logic [2:0] REASON_STALE     = 3'd1;
   localparam logic [2:0] REASON_MALFORMED = 3'd2;
   localparam logic [2:0] REASON_REPLAYED  = 3'd3;
   localparam logic [2:0] REASON_BADSIG    = 3'd4;

   typedef struct packed {
      logic load;      // capture a new transaction
      logic diff_en;   // register the time difference
      logic stale_en;  // register the window compare
      logic rd_en;     // read one ring entry for the replay scan
      logic wr_en;     // record the nonce at the ring head
   } crg_cmd_type;

   typedef struct packed {
      logic stale;
      logic malformed;
      logic hit;
      logic sig_ok;
   } crg_status_type;

endpackage

// File: rtl/crg_ram.sv
module crg_ram #(
   parameter int WIDTH = 128,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/crg_dp.sv
module crg_dp
   import crg_pkg::*;
#(
   parameter int RING_SIZE   = 16,
   parameter int NONCE_BYTES = 16,
   localparam int AW = (RING_SIZE > 1) ? $clog2(RING_SIZE) : 1,
   localparam int NW = 8 * NONCE_BYTES
) (
   input  logic           clock,
   input  logic           reset,
   input  logic [63:0]    req_nonce_low,
   input  logic [63:0]    req_nonce_high,
   input  logic [4:0]     req_nonce_length,
   input  logic [31:0]    req_command_time,
   input  logic [31:0]    req_current_time,
   input  logic           req_signature_ok,
   input  logic           csr_valid,
   output logic           csr_ready,
   input  logic [31:0]    csr_window_seconds,
   input  crg_cmd_type    cmd,
   input  logic [AW-1:0]  ram_addr,
   output crg_status_type status
);

   logic [127:0]  nonce_full;
   logic [NW-1:0] nonce_masked;
   logic [NW-1:0] nonce_ff;
   logic [NW-1:0] rd_data;
   logic [31:0]   cmd_time_ff;
   logic [31:0]   cur_time_ff;
   logic [31:0]   diff_ff;
   logic [31:0]   window_ff;
   logic          sig_ff;
   logic          malformed_ff;
   logic          sync_ff;
   logic          stale_ff;
   logic          hit_ff;
   logic          hit_in;
   logic          cmp_pend_ff;

   assign nonce_full = {req_nonce_high, req_nonce_low};

   // zero every byte at or past the nonce length
   always_comb begin
      for (int i = 0; i < NONCE_BYTES; i++) begin
         nonce_masked[8*i +: 8] = (5'(i) < req_nonce_length) ? nonce_full[8*i +: 8] : 8'h00;
      end
   end

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= WINDOW_RESET;
      end else if (csr_valid && csr_ready) begin
         window_ff <= csr_window_seconds;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         nonce_ff     <= nonce_masked;
         cmd_time_ff  <= req_command_time;
         cur_time_ff  <= req_current_time;
         sig_ff       <= req_signature_ok;
         malformed_ff <= (req_nonce_length == 5'd0) ||
                         (req_nonce_length >= 5'(NONCE_BYTES));
         sync_ff      <= req_current_time > SYNC_THRESHOLD;
      end
      if (cmd.diff_en) begin
         diff_ff <= (cmd_time_ff > cur_time_ff) ? (cmd_time_ff - cur_time_ff)
                                                : (cur_time_ff - cmd_time_ff);
      end
      if (cmd.stale_en) begin
         stale_ff <= sync_ff && (diff_ff > window_ff);
      end
   end

   // compare the entry read in the previous cycle
   always_comb begin
      hit_in = hit_ff;
      if (cmd.load) begin
         hit_in = 1'b0;
      end else if (cmp_pend_ff && (rd_data == nonce_ff)) begin
         hit_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hit_ff      <= 1'b0;
         cmp_pend_ff <= 1'b0;
      end else begin
         hit_ff      <= hit_in;
         cmp_pend_ff <= cmd.rd_en;
      end
   end

   crg_ram #(
      .WIDTH (NW),
      .DEPTH (RING_SIZE)
   ) u_ring (
      .clock   (clock),
      .wr_en   (cmd.wr_en),
      .wr_addr (ram_addr),
      .wr_data (nonce_ff),
      .rd_en   (cmd.rd_en),
      .rd_addr (ram_addr),
      .rd_data (rd_data)
   );

   assign status.stale     = stale_ff;
   assign status.malformed = malformed_ff;
   assign status.hit       = hit_ff;
   assign status.sig_ok    = sig_ff;

endmodule

// File: rtl/crg_ctrl.sv
module crg_ctrl
   import crg_pkg::*;
#(
   parameter int RING_SIZE = 16,
   localparam int AW = (RING_SIZE > 1) ? $clog2(RING_SIZE) : 1,
   localparam int CW = $clog2(RING_SIZE + 1)
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_stall,
   output logic           rsp_valid,
   input  logic           rsp_stall,
   output logic           rsp_accepted,
   output logic [2:0]     rsp_reject_reason,
   output crg_cmd_type    cmd,
   output logic [AW-1:0]  ram_addr,
   input  crg_status_type status
);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_DIFF   = 3'd1;
   localparam logic [2:0] S_LIMIT  = 3'd2;
   localparam logic [2:0] S_SCAN   = 3'd3;
   localparam logic [2:0] S_DECIDE = 3'd4;

   logic [2:0]    state_ff, state_in;
   logic [CW-1:0] idx_ff, idx_in;
   logic [CW-1:0] filled_ff, filled_in;
   logic [AW-1:0] head_ff, head_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          rsp_accepted_ff, rsp_accepted_in;
   logic [2:0]    rsp_reason_ff, rsp_reason_in;
   logic [2:0]    reason;
   logic          rsp_free;

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      if (status.stale) begin
         reason = REASON_STALE;
      end else if (status.malformed) begin
         reason = REASON_MALFORMED;
      end else if (status.hit) begin
         reason = REASON_REPLAYED;
      end else if (!status.sig_ok) begin
         reason = REASON_BADSIG;
      end else begin
         reason = REASON_NONE;
      end
   end

   always_comb begin
      state_in        = state_ff;
      idx_in          = idx_ff;
      filled_in       = filled_ff;
      head_in         = head_ff;
      rsp_valid_in    = rsp_valid_ff && rsp_stall;
      rsp_accepted_in = rsp_accepted_ff;
      rsp_reason_in   = rsp_reason_ff;
      cmd             = '0;
      ram_addr        = idx_ff[AW-1:0];
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               idx_in   = '0;
               state_in = S_DIFF;
            end
         end
         S_DIFF: begin
            cmd.diff_en = 1'b1;
            state_in    = S_LIMIT;
         end
         S_LIMIT: begin
            cmd.stale_en = 1'b1;
            state_in     = S_SCAN;
         end
         S_SCAN: begin
            // one entry per cycle; the last compare lands as we leave
            if (idx_ff < filled_ff) begin
               cmd.rd_en = 1'b1;
               idx_in    = idx_ff + 1'b1;
            end else begin
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            ram_addr = head_ff;
            if (rsp_free) begin
               rsp_valid_in    = 1'b1;
               rsp_accepted_in = (reason == REASON_NONE);
               rsp_reason_in   = reason;
               if (reason == REASON_NONE) begin
                  cmd.wr_en = 1'b1;
                  head_in   = (head_ff == AW'(RING_SIZE - 1)) ? '0 : head_ff + 1'b1;
                  if (filled_ff != CW'(RING_SIZE)) begin
                     filled_in = filled_ff + 1'b1;
                  end
               end
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         idx_ff       <= '0;
         filled_ff    <= '0;
         head_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         filled_ff    <= filled_in;
         head_ff      <= head_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_accepted_ff <= rsp_accepted_in;
      rsp_reason_ff   <= rsp_reason_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_accepted      = rsp_accepted_ff;
   assign rsp_reject_reason = rsp_reason_ff;

endmodule

// File: rtl/command_replay_guard.sv
// channel   direction  handshake            payload
// req       in         req_valid/req_stall  nonce_low/high, nonce_length, command_time,
//                                           current_time, signature_ok
// rsp       out        rsp_valid/rsp_stall  accepted, reject_reason
// csr       in         csr_valid/csr_ready  window_seconds
//
// rsp_valid rises after the DIFF, LIMIT, SCAN and DECIDE states, DECIDE waiting while a
// stalled result holds the output register; the next transaction is then taken. SCAN
// reads the filled recorded entries (at most RING_SIZE) one per cycle from ring memory.
// Reset is synchronous: it clears ring head and fill count and loads a window of 300.
// A stalled result holds in the output register; the next transaction is still taken
// and its result waits until the register frees.
module command_replay_guard
   import crg_pkg::*;
#(
   parameter int RING_SIZE   = 16,
   parameter int NONCE_BYTES = 16,
   localparam int AW = (RING_SIZE > 1) ? $clog2(RING_SIZE) : 1
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [63:0] req_nonce_low,
   input  logic [63:0] req_nonce_high,
   input  logic [4:0]  req_nonce_length,
   input  logic [31:0] req_command_time,
   input  logic [31:0] req_current_time,
   input  logic        req_signature_ok,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_accepted,
   output logic [2:0]  rsp_reject_reason,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [31:0] csr_window_seconds
);

   crg_cmd_type    cmd;
   crg_status_type status;
   logic [AW-1:0]  ram_addr;

   crg_ctrl #(
      .RING_SIZE (RING_SIZE)
   ) u_ctrl (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_accepted      (rsp_accepted),
      .rsp_reject_reason (rsp_reject_reason),
      .cmd               (cmd),
      .ram_addr          (ram_addr),
      .status            (status)
   );

   crg_dp #(
      .RING_SIZE   (RING_SIZE),
      .NONCE_BYTES (NONCE_BYTES)
   ) u_dp (
      .clock              (clock),
      .reset              (reset),
      .req_nonce_low      (req_nonce_low),
      .req_nonce_high     (req_nonce_high),
      .req_nonce_length   (req_nonce_length),
      .req_command_time   (req_command_time),
      .req_current_time   (req_current_time),
      .req_signature_ok   (req_signature_ok),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_window_seconds (csr_window_seconds),
      .cmd                (cmd),
      .ram_addr           (ram_addr),
      .status             (status)
   );

endmodule

// File: rtl/crg_checker.sv
module crg_checker
   import crg_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic        rsp_accepted,
   input logic [2:0]  rsp_reject_reason
);

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_accepted) &&
                                 $stable(rsp_reject_reason))
      else $error("result changed while stalled");

   a_accept_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_accepted == (rsp_reject_reason == REASON_NONE)))
      else $error("accepted flag disagrees with reject reason");

   a_reason_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_reject_reason == REASON_NONE) ||
                    (rsp_reject_reason == REASON_STALE) ||
                    (rsp_reject_reason == REASON_MALFORMED) ||
                    (rsp_reject_reason == REASON_REPLAYED) ||
                    (rsp_reject_reason == REASON_BADSIG))
      else $error("reject reason out of range");

   // one transaction at a time: the guard is busy right after an accept
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("input not stalled after accept");

   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind command_replay_guard crg_checker u_crg_checker (.*);
